// ===== design/tqps_pkg.sv =====
// ----------------------------------------------------------------------------
// tqps_pkg: shared types and constants for the ticket queue
// Word formats, command and status codes, and the control structs that the
// queue controller drives into the row of storage cells.
// ----------------------------------------------------------------------------
`default_nettype none

package tqps_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TICKET_W = 16;
    localparam int SIZE_W = 8;

    localparam logic [SIZE_W-1:0] RESET_SEATS = SIZE_W'(4);
    localparam logic [TICKET_W-1:0] FIRST_TICKET = TICKET_W'(1);

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_SERVE   = 2'd1,
        OP_CANCEL  = 2'd2,
        OP_LOOKUP  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        opcode_t              opcode;
        logic [SIZE_W-1:0]    group_size;
        logic [TICKET_W-1:0]  ticket;
    } in_word_t;

    typedef struct packed {
        status_t              status;
        logic [SIZE_W-1:0]    group_count;
        logic [TICKET_W-1:0]  assigned_ticket;
        logic                 still_waiting;
    } out_word_t;

    typedef struct packed {
        logic [TICKET_W-1:0]  key;
        logic [TICKET_W-1:0]  new_ticket;
        logic [SIZE_W-1:0]    new_size;
        logic                 enqueue;
        logic                 remove_head;
        logic                 remove_match;
        logic                 reduce;
    } cell_cmd_t;

    typedef struct packed {
        logic                 occupied;
        logic                 tail;
        logic                 free;
        logic                 head;
    } slot_t;

endpackage

`default_nettype wire

// ===== design/tqps_cell.sv =====
// ----------------------------------------------------------------------------
// tqps_cell: one queue slot
// Holds one group's ticket and size, compares the ticket with the search key,
// passes the first-match flag on toward the tail, and takes its neighbor's
// contents when it or an entry ahead of it is removed.
// ----------------------------------------------------------------------------
`default_nettype none

module tqps_cell
    import tqps_pkg::*;
(
    input  wire logic                 clk,
    input  wire cell_cmd_t            cmd,
    input  wire slot_t                slot,
    input  wire logic                 found_in,
    input  wire logic [TICKET_W-1:0]  next_ticket,
    input  wire logic [SIZE_W-1:0]    next_size,
    output logic [TICKET_W-1:0]       ticket,
    output logic [SIZE_W-1:0]         size,
    output logic                      found_out,
    output logic [SIZE_W-1:0]         hit_size,
    output logic [TICKET_W-1:0]       tail_ticket
);

    logic [TICKET_W-1:0] ticket_reg;
    logic [TICKET_W-1:0] ticket_next;
    logic [SIZE_W-1:0]   size_reg;
    logic [SIZE_W-1:0]   size_next;
    logic                match;

    always_comb
    begin
        match       = slot.occupied && (ticket_reg == cmd.key);
        found_out   = found_in | match;
        hit_size    = (match && !found_in) ? size_reg : '0;
        tail_ticket = slot.tail ? ticket_reg : '0;
        ticket      = ticket_reg;
        size        = size_reg;
    end

    always_comb
    begin
        ticket_next = ticket_reg;
        size_next   = size_reg;
        priority if (cmd.remove_head || (cmd.remove_match && found_out))
        begin
            ticket_next = next_ticket;
            size_next   = next_size;
        end
        else if (cmd.enqueue && slot.free)
        begin
            ticket_next = cmd.new_ticket;
            size_next   = cmd.new_size;
        end
        else if (cmd.reduce && slot.head)
        begin
            size_next = cmd.new_size;
        end
    end

    always_ff @(posedge clk)
    begin
        ticket_reg <= ticket_next;
        size_reg   <= size_next;
    end

endmodule

`default_nettype wire

// ===== design/ticket_queue_partial_serve.sv =====
// ----------------------------------------------------------------------------
// ticket_queue_partial_serve: ordered queue of ticketed groups
// Enqueue, partial serve of the head, cancel and lookup by ticket, built as
// a row of storage cells with a small command controller.
// ----------------------------------------------------------------------------
// Each command word is registered when accepted; in the ST_EXEC state every
// cell compares its ticket against the key, the first-match flag ripples down
// the row of cells, and the row shifts toward the head, trims the head size or
// writes the tail in one step while the result word is loaded. A new command
// is taken only in ST_IDLE, after the last one has fired; a waiting result that
// is not drained holds the command in ST_EXEC.
// seats_reg resets to 4 and is written with cfg_we at any edge.
`default_nettype none

module ticket_queue_partial_serve
    import tqps_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire in_word_t           in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output out_word_t               out_data,
    input  wire logic               cfg_we,
    input  wire logic [SIZE_W-1:0]  cfg_data
);

    state_t             state_reg;
    state_t             state_next;
    in_word_t           cmd_reg;
    logic [OCC_W-1:0]   occ_reg;
    logic [OCC_W-1:0]   occ_next;
    logic [SIZE_W-1:0]  seats_reg;
    out_word_t          out_reg;
    out_word_t          out_next;
    logic               out_valid_reg;
    logic               fire;

    cell_cmd_t          cell_cmd;
    slot_t              slots       [QUEUE_DEPTH];
    logic [TICKET_W-1:0] tickets    [QUEUE_DEPTH+1];
    logic [SIZE_W-1:0]  sizes       [QUEUE_DEPTH+1];
    logic               found       [QUEUE_DEPTH+1];
    logic [SIZE_W-1:0]  hit_sizes   [QUEUE_DEPTH];
    logic [TICKET_W-1:0] tail_tickets [QUEUE_DEPTH];
    logic [SIZE_W-1:0]  hit_size;
    logic [TICKET_W-1:0] tail_ticket;
    logic               empty;
    logic               full;

    assign tickets[QUEUE_DEPTH] = '0;
    assign sizes[QUEUE_DEPTH]   = '0;
    assign found[0]             = 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        always_comb
        begin
            slots[i].occupied = OCC_W'(i) < occ_reg;
            slots[i].tail     = OCC_W'(i + 1) == occ_reg;
            slots[i].free     = OCC_W'(i) == occ_reg;
            slots[i].head     = (i == 0);
        end

        tqps_cell u_cell (
            .clk         (clk),
            .cmd         (cell_cmd),
            .slot        (slots[i]),
            .found_in    (found[i]),
            .next_ticket (tickets[i+1]),
            .next_size   (sizes[i+1]),
            .ticket      (tickets[i]),
            .size        (sizes[i]),
            .found_out   (found[i+1]),
            .hit_size    (hit_sizes[i]),
            .tail_ticket (tail_tickets[i])
        );
    end

    always_comb
    begin
        hit_size    = '0;
        tail_ticket = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            hit_size    = hit_size | hit_sizes[i];
            tail_ticket = tail_ticket | tail_tickets[i];
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign empty     = (occ_reg == '0);
    assign full      = (occ_reg == OCC_W'(QUEUE_DEPTH));

    always_comb
    begin
        state_next = state_reg;
        fire       = 1'b0;
        occ_next   = occ_reg;
        out_next   = '{status: STATUS_OK, default: '0};
        cell_cmd   = '0;
        cell_cmd.key = cmd_reg.ticket;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    fire       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd_reg.opcode == OP_ENQUEUE)
        begin
            if (full)
            begin
                out_next.status = STATUS_FULL;
            end
            else
            begin
                cell_cmd.new_ticket = empty ? FIRST_TICKET : tail_ticket + TICKET_W'(1);
                cell_cmd.new_size   = cmd_reg.group_size;
                cell_cmd.enqueue    = fire;
                out_next.assigned_ticket = cell_cmd.new_ticket;
                occ_next = occ_reg + OCC_W'(1);
            end
        end
        else if (empty)
        begin
            out_next.status = STATUS_EMPTY;
        end
        else if (cmd_reg.opcode == OP_SERVE)
        begin
            out_next.group_count = sizes[0];
            if (sizes[0] <= seats_reg)
            begin
                cell_cmd.remove_head = fire;
                occ_next = occ_reg - OCC_W'(1);
            end
            else
            begin
                cell_cmd.new_size = sizes[0] - seats_reg;
                cell_cmd.reduce   = fire;
                out_next.still_waiting = 1'b1;
            end
        end
        else if (!found[QUEUE_DEPTH])
        begin
            out_next.status = STATUS_NOT_FOUND;
        end
        else
        begin
            out_next.group_count = hit_size;
            if (cmd_reg.opcode == OP_CANCEL)
            begin
                cell_cmd.remove_match = fire;
                occ_next = occ_reg - OCC_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            seats_reg     <= RESET_SEATS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                seats_reg <= cfg_data;
            end
            if (fire)
            begin
                occ_reg       <= occ_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= in_data;
        end
        if (fire)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

// ===== sim/tb_ticket_queue_partial_serve.sv =====
// ----------------------------------------------------------------------------
// tb_ticket_queue_partial_serve: self-checking bench for the ticket queue
// Drives command words through the valid/ready input channel and keeps a
// shadow copy of the queue that predicts every result word. Results are
// checked in order, field by field. A directed opening covers the empty
// and full queue, missing tickets, zero-size groups and a zero seat count.
// After that, random phases with varied seat counts and idle patterns follow.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ticket_queue_partial_serve;
    import tqps_pkg::*;

    class queue_scoreboard;
        logic [TICKET_W-1:0] tickets [QUEUE_DEPTH];
        logic [SIZE_W-1:0]   sizes [QUEUE_DEPTH];
        int                  occ;
        logic [SIZE_W-1:0]   seats;
        out_word_t           expected_q [$];
        int                  errors;

        function new();
            occ = 0;
            seats = RESET_SEATS;
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void drop_entry(int pos);
            for (int i = pos; i + 1 < occ; i++)
            begin
                tickets[i] = tickets[i + 1];
                sizes[i] = sizes[i + 1];
            end
            occ--;
        endfunction

        function void note_command(in_word_t w);
            out_word_t want;
            int        pos;
            want = '0;
            want.status = STATUS_OK;
            pos = -1;
            if (w.opcode == OP_ENQUEUE)
            begin
                if (occ >= QUEUE_DEPTH)
                begin
                    want.status = STATUS_FULL;
                end
                else
                begin
                    want.assigned_ticket = (occ == 0) ? FIRST_TICKET
                                                      : tickets[occ - 1] + 1'b1;
                    tickets[occ] = want.assigned_ticket;
                    sizes[occ] = w.group_size;
                    occ++;
                end
            end
            else if (occ == 0)
            begin
                want.status = STATUS_EMPTY;
            end
            else if (w.opcode == OP_SERVE)
            begin
                want.group_count = sizes[0];
                if (sizes[0] <= seats)
                begin
                    drop_entry(0);
                end
                else
                begin
                    sizes[0] = sizes[0] - seats;
                    want.still_waiting = 1'b1;
                end
            end
            else
            begin
                for (int i = occ - 1; i >= 0; i--)
                begin
                    if (tickets[i] == w.ticket)
                        pos = i;
                end
                if (pos < 0)
                begin
                    want.status = STATUS_NOT_FOUND;
                end
                else
                begin
                    want.group_count = sizes[pos];
                    if (w.opcode == OP_CANCEL)
                        drop_entry(pos);
                end
            end
            expected_q.push_back(want);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                errors++;
                if (errors <= 50)
                    $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            end
        endfunction

        function void check_reply(out_word_t got);
            out_word_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 50)
                    $display("%0t: result word expected none got %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            compare_field("status", 16'(want.status), 16'(got.status));
            compare_field("group_count", 16'(want.group_count), 16'(got.group_count));
            compare_field("assigned_ticket", want.assigned_ticket, got.assigned_ticket);
            compare_field("still_waiting", 16'(want.still_waiting), 16'(got.still_waiting));
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    in_word_t            in_data;
    logic                out_valid;
    logic                out_ready;
    out_word_t           out_data;
    logic                cfg_we;
    logic [SIZE_W-1:0]   cfg_data;

    int                  send_idle_pct;
    int                  recv_stall_pct;
    bit                  filling;
    queue_scoreboard     sb = new();

    ticket_queue_partial_serve dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
                sb.check_reply(out_data);
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_cmd(opcode_t op, logic [SIZE_W-1:0] size, logic [TICKET_W-1:0] tk);
        in_word_t w;
        w.opcode = op;
        w.group_size = size;
        w.ticket = tk;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_command(w);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_seats(logic [SIZE_W-1:0] value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.seats = value;
    endtask

    task automatic run_random(int count);
        in_word_t w;
        int       idx;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(59) == 0)
                filling = !filling;
            w.group_size = ($urandom_range(3) == 0) ? SIZE_W'($urandom)
                                                    : SIZE_W'($urandom_range(12));
            w.ticket = TICKET_W'($urandom);
            if ($urandom_range(99) < (filling ? 60 : 25))
            begin
                w.opcode = OP_ENQUEUE;
            end
            else
            begin
                case ($urandom_range(2))
                    0: w.opcode = OP_SERVE;
                    1: w.opcode = OP_CANCEL;
                    default: w.opcode = OP_LOOKUP;
                endcase
                if (sb.occ > 0 && $urandom_range(99) < 75)
                begin
                    idx = $urandom_range(sb.occ - 1);
                    w.ticket = sb.tickets[idx];
                    if ($urandom_range(9) == 0)
                        w.ticket = w.ticket + 1'b1;
                end
            end
            send_cmd(w.opcode, w.group_size, w.ticket);
        end
    endtask

    initial
    begin
        #500_000;
        $display("tb_ticket_queue_partial_serve NOT OK");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_data = RESET_SEATS;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        filling = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_cmd(OP_SERVE, 8'hFF, 16'hFFFF);
        send_cmd(OP_CANCEL, 8'h00, 16'h0001);
        send_cmd(OP_LOOKUP, 8'h00, 16'h0000);
        send_cmd(OP_ENQUEUE, 8'h00, 16'hFFFF);
        send_cmd(OP_ENQUEUE, 8'hFF, 16'h0000);
        for (int i = 0; i < QUEUE_DEPTH - 2; i++)
            send_cmd(OP_ENQUEUE, SIZE_W'(i + 1), 16'h0000);
        send_cmd(OP_ENQUEUE, 8'h55, 16'h0000);
        send_cmd(OP_LOOKUP, 8'h00, 16'h0001);
        send_cmd(OP_LOOKUP, 8'h00, 16'h0010);
        send_cmd(OP_LOOKUP, 8'h00, 16'h0011);
        send_cmd(OP_CANCEL, 8'h00, 16'h0005);
        send_cmd(OP_LOOKUP, 8'h00, 16'h0005);
        send_cmd(OP_ENQUEUE, 8'h07, 16'h0000);
        send_cmd(OP_CANCEL, 8'h00, 16'h0011);
        send_cmd(OP_ENQUEUE, 8'h09, 16'h0000);
        send_cmd(OP_SERVE, 8'h00, 16'h0000);
        send_cmd(OP_SERVE, 8'h00, 16'h0000);

        // With no seats a serve leaves a head group of nonzero size untouched.
        write_seats(8'd0);
        send_cmd(OP_SERVE, 8'h00, 16'h0000);
        send_cmd(OP_SERVE, 8'hFF, 16'hFFFF);

        // Fill the queue again and probe tickets that are not held.
        write_seats(8'd255);
        while (sb.occ < QUEUE_DEPTH)
            send_cmd(OP_ENQUEUE, SIZE_W'($urandom_range(255)), 16'h0000);
        send_cmd(OP_LOOKUP, 8'h00, 16'h0000);
        send_cmd(OP_LOOKUP, 8'h00, 16'hFFFF);
        send_cmd(OP_CANCEL, 8'h00, 16'h0000);
        send_cmd(OP_ENQUEUE, 8'h03, 16'h0000);
        run_random(200);

        write_seats(8'd1);
        run_random(300);

        write_seats(SIZE_W'($urandom_range(2, 20)));
        send_idle_pct = 52;
        recv_stall_pct = 0;
        run_random(300);

        write_seats(8'd255);
        send_idle_pct = 0;
        recv_stall_pct = 52;
        run_random(300);

        write_seats(SIZE_W'($urandom_range(1, 255)));
        send_idle_pct = 18;
        recv_stall_pct = 18;
        run_random(300);

        wait_idle();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_ticket_queue_partial_serve OK");
        else
            $display("tb_ticket_queue_partial_serve NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
